FILE: rtl/smmd_pkg.sv
package smmd_pkg;

    localparam int VALUE_WIDTH = 32;

    // Flip the sign bit to turn a two's complement value into an unsigned order key
    localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    // Distinct values seen so far, saturating
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last_item;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] low_runner_up;
        logic signed [VALUE_WIDTH-1:0] high_runner_up;
        logic                          found;
    } out_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] key;
        logic                   last;
    } cmd_t;

endpackage

FILE: rtl/smmd_front.sv
module smmd_front
    import smmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    output logic fwd_valid,
    input  logic fwd_ready,
    output cmd_t fwd_cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    logic take;

    assign full      = valid_reg && !fwd_ready;
    assign take      = push && !full;
    assign fwd_valid = valid_reg;
    assign fwd_cmd   = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fwd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Classify: turn the value into its order key and keep the end-of-set mark
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.key  <= item.value ^ SIGN_BIT;
            cmd_reg.last <= item.last_item;
        end
    end

endmodule

FILE: rtl/smmd_queue.sv
module smmd_queue
    import smmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_take,
    output cmd_t rd_cmd
);

    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    cmd_t                   mem_reg [QUEUE_DEPTH];
    logic                   do_wr;
    logic                   do_rd;

    assign wr_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: rtl/smmd_back.sv
module smmd_back
    import smmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_take,
    input  cmd_t cmd,
    output logic empty,
    input  logic pop,
    output out_t result
);

    logic [VALUE_WIDTH-1:0] lf_reg, lf_next;
    logic [VALUE_WIDTH-1:0] ls_reg, ls_next;
    logic [VALUE_WIDTH-1:0] hf_reg, hf_next;
    logic [VALUE_WIDTH-1:0] hs_reg, hs_next;
    logic [1:0]             seen_reg, seen_next;
    logic [1:0]             seen_upd;

    logic [QUEUE_CNT_W-1:0] out_cnt_reg;
    logic [QUEUE_CNT_W-1:0] out_cnt_next;
    logic [QUEUE_PTR_W-1:0] out_wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] out_rd_ptr_reg;
    out_t                   out_mem_reg [QUEUE_DEPTH];

    logic                   out_room;
    logic                   out_push;
    logic                   out_pop;
    logic                   found;
    out_t                   res;

    assign out_room = out_cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign cmd_take = cmd_valid && (!cmd.last || out_room);
    assign out_push = cmd_take && cmd.last;
    assign empty    = out_cnt_reg == '0;
    assign out_pop  = pop && !empty;
    assign result   = out_mem_reg[out_rd_ptr_reg];

    // Fold one key into the four extremes
    always_comb
    begin
        lf_next  = lf_reg;
        ls_next  = ls_reg;
        hf_next  = hf_reg;
        hs_next  = hs_reg;
        seen_upd = seen_reg;
        unique case (seen_reg)
            SEEN_ONE:
            begin
                if (cmd.key < lf_reg)
                begin
                    ls_next  = lf_reg;
                    hs_next  = cmd.key;
                    lf_next  = cmd.key;
                    seen_upd = SEEN_TWO;
                end
                else if (cmd.key > lf_reg)
                begin
                    ls_next  = cmd.key;
                    hs_next  = lf_reg;
                    hf_next  = cmd.key;
                    seen_upd = SEEN_TWO;
                end
            end
            SEEN_TWO:
            begin
                if (cmd.key < lf_reg)
                begin
                    ls_next = lf_reg;
                    lf_next = cmd.key;
                end
                else if (cmd.key > lf_reg && cmd.key < ls_reg)
                begin
                    ls_next = cmd.key;
                end
                if (cmd.key > hf_reg)
                begin
                    hs_next = hf_reg;
                    hf_next = cmd.key;
                end
                else if (cmd.key < hf_reg && cmd.key > hs_reg)
                begin
                    hs_next = cmd.key;
                end
            end
            default:
            begin
                lf_next  = cmd.key;
                hf_next  = cmd.key;
                seen_upd = SEEN_ONE;
            end
        endcase

        found              = seen_upd == SEEN_TWO;
        res.found          = found;
        res.low_runner_up  = found ? $signed(ls_next ^ SIGN_BIT) : '1;
        res.high_runner_up = found ? $signed(hs_next ^ SIGN_BIT) : '1;

        // Drop the set after its last item
        seen_next = cmd.last ? SEEN_NONE : seen_upd;
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (out_push && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 1'b1;
        end
        else if (out_pop && !out_push)
        begin
            out_cnt_next = out_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= SEEN_NONE;
            out_cnt_reg    <= '0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                seen_reg <= seen_next;
            end
            out_cnt_reg <= out_cnt_next;
            if (out_push)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            lf_reg <= lf_next;
            ls_reg <= ls_next;
            hf_reg <= hf_next;
            hs_reg <= hs_next;
        end
        if (out_push)
        begin
            out_mem_reg[out_wr_ptr_reg] <= res;
        end
    end

`ifndef SYNTH
    a_out_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("distinct count out of range");

    a_one_value: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg == SEEN_ONE |-> lf_reg == hf_reg)
        else $error("single value not mirrored in both extremes");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg == SEEN_TWO |-> (lf_reg < ls_reg) && (hs_reg < hf_reg))
        else $error("extremes out of order");
`endif

endmodule

FILE: rtl/second_min_max_distinct.sv
// Path: front register, then command queue, then back end and result queue.
// Throughput: one request per clock unless a full result queue stalls a last
// item. The four extremes update by combinational compare-and-select.
// Full rises only when the front register, the 2-entry command queue and the
// 2-entry result queue are all backed up by a stalled consumer.
// Reset (rst_n low, asynchronous): all queues empty, the set is cleared.
module second_min_max_distinct
    import smmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  item,
    output logic empty,
    input  logic pop,
    output out_t result
);

    // Front to queue
    logic fwd_valid;
    logic fwd_ready;
    cmd_t fwd_cmd;

    // Queue to back end
    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    // Front end: register each request and turn its value into an order key
    smmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .fwd_valid (fwd_valid),
        .fwd_ready (fwd_ready),
        .fwd_cmd   (fwd_cmd)
    );

    // Short command queue: lets the front keep accepting while the back stalls
    smmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fwd_valid),
        .wr_ready (fwd_ready),
        .wr_cmd   (fwd_cmd),
        .rd_valid (cmd_valid),
        .rd_take  (cmd_take),
        .rd_cmd   (cmd)
    );

    // Back end: fold keys into the extremes, emit a result on the last item
    smmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: test/tb_second_min_max_distinct.sv
`timescale 1ns / 1ps

module tb_second_min_max_distinct;
    import smmd_pkg::*;

    typedef logic signed [VALUE_WIDTH-1:0] sval_t;

    localparam sval_t VMIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
    localparam sval_t VMAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    localparam sval_t NOT_FOUND = '1;

    // Longest run of cycles with no request moving on either side before giving up.
    // The deliberate receiver hold-off is well below this.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles to keep watching the result side once everything has come back.
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    in_t item = '0;
    logic full;
    logic empty;
    out_t result;

    second_min_max_distinct dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Requests waiting to be offered; the head is what the driver puts on the bus.
    in_t queued_requests[$];
    // Answers the block owes us, oldest first.
    out_t expected_runner_ups[$];

    // Shadow copy of the block's set state.
    sval_t low_first, low_second, high_first, high_second;
    logic [1:0] seen_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_asks = 0;
    int hold_off_taken = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    bit req_taken = 1'b0;
    bit moved;
    out_t want;

    task automatic clear_set();
        low_first = '0;
        low_second = '0;
        high_first = '0;
        high_second = '0;
        seen_count = SEEN_NONE;
    endtask

    // Fold one value into the running extremes, dropping anything already held.
    task automatic fold_value(input sval_t v);
        if (seen_count == SEEN_NONE)
        begin
            low_first = v;
            high_first = v;
            seen_count = SEEN_ONE;
        end
        else if (seen_count == SEEN_ONE)
        begin
            if (v != low_first)
            begin
                // Two distinct values now: each one is runner-up on the other side.
                if (v < low_first)
                begin
                    low_second = low_first;
                    high_second = v;
                    low_first = v;
                end
                else
                begin
                    low_second = v;
                    high_second = low_first;
                    high_first = v;
                end
                seen_count = SEEN_TWO;
            end
        end
        else
        begin
            if (v < low_first)
            begin
                low_second = low_first;
                low_first = v;
            end
            else if (v > low_first && v < low_second)
            begin
                low_second = v;
            end
            if (v > high_first)
            begin
                high_second = high_first;
                high_first = v;
            end
            else if (v < high_first && v > high_second)
            begin
                high_second = v;
            end
        end
    endtask

    // Predict the block for one accepted request; a marked request closes the set.
    task automatic track_extremes(input in_t req);
        out_t ans;
        fold_value(req.value);
        if (req.last_item)
        begin
            if (seen_count == SEEN_TWO)
            begin
                ans.low_runner_up = low_second;
                ans.high_runner_up = high_second;
                ans.found = 1'b1;
            end
            else
            begin
                ans.low_runner_up = NOT_FOUND;
                ans.high_runner_up = NOT_FOUND;
                ans.found = 1'b0;
            end
            expected_runner_ups.push_back(ans);
            clear_set();
        end
    endtask

    task automatic add_request(input sval_t v, input logic last);
        in_t req;
        req.value = v;
        req.last_item = last;
        queued_requests.push_back(req);
    endtask

    // Mix extremes, a narrow band around zero (plenty of duplicates and -1)
    // and full-width noise so every bit toggles.
    function automatic sval_t pick_value();
        sval_t v;
        int s;
        case ($urandom_range(7)) inside
            0: v = VMIN;
            1: v = VMAX;
            2, 3:
            begin
                s = $urandom_range(8);
                v = s - 4;
            end
            4:
            begin
                s = $urandom_range(2);
                v = s - 1;
            end
            default: v = sval_t'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    // Queue whole sets until at least n_items have been added, so each batch ends marked.
    task automatic add_random_sets(input int n_items, input int max_len);
        int added;
        int len;
        added = 0;
        while (added < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(max_len, 1);
            for (int i = 0; i < len; i++)
                add_request(pick_value(), i == len - 1);
            added += len;
        end
    endtask

    task automatic wait_requests_sent();
        while (queued_requests.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_answers_in();
        while (queued_requests.size() != 0 || expected_runner_ups.size() != 0)
            @(posedge clk);
    endtask

    // Driver: change inputs on the falling edge only. Hold a request that the
    // block has not taken yet; otherwise offer the head of the queue unless idling.
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !req_taken)
            ;
        else if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push <= 1'b1;
            item <= queued_requests[0];
        end
        else
            push <= 1'b0;
    end

    // Receiver: pop at random, or hold off completely for a long stretch when asked.
    always @(negedge clk)
    begin
        if (hold_off_asks != hold_off_taken)
        begin
            hold_off_taken = hold_off_asks;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_off_left > 0)
        begin
            hold_off_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: sample both handshakes on the rising edge, predict on accepted
    // requests and check every popped answer against the oldest expectation.
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        moved = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                req_taken = 1'b1;
                moved = 1'b1;
                void'(queued_requests.pop_front());
                track_extremes(item);
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (expected_runner_ups.size() == 0)
                begin
                    $error("answer with none expected: %0d %0d found=%0b",
                           result.low_runner_up, result.high_runner_up, result.found);
                    mismatches++;
                end
                else
                begin
                    want = expected_runner_ups.pop_front();
                    if (result.low_runner_up !== want.low_runner_up)
                    begin
                        $error("low_runner_up expected %0d got %0d",
                               want.low_runner_up, result.low_runner_up);
                        mismatches++;
                    end
                    if (result.high_runner_up !== want.high_runner_up)
                    begin
                        $error("high_runner_up expected %0d got %0d",
                               want.high_runner_up, result.high_runner_up);
                        mismatches++;
                    end
                    if (result.found !== want.found)
                    begin
                        $error("found expected %0b got %0b", want.found, result.found);
                        mismatches++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        clear_set();
        fork
            begin
                repeat (11) @(posedge clk);
                @(negedge clk);
                rst_n <= 1'b1;
                @(posedge clk);

                // Directed sets. One element only: nothing to report.
                add_request(0, 1'b1);
                // Repeated copies of one value: still nothing.
                add_request(5, 1'b0);
                add_request(5, 1'b0);
                add_request(5, 1'b1);
                // Two distinct extremes: each one is the other's runner-up.
                add_request(VMIN, 1'b0);
                add_request(VMAX, 1'b1);
                // A genuine -1 answer with found set.
                add_request(-2, 1'b0);
                add_request(-1, 1'b0);
                add_request(0, 1'b1);
                // Extremes and duplicates in one set.
                add_request(VMAX, 1'b0);
                add_request(0, 1'b0);
                add_request(VMIN, 1'b0);
                add_request(VMAX, 1'b0);
                add_request(1, 1'b0);
                add_request(-1, 1'b0);
                add_request(VMIN, 1'b0);
                add_request(7, 1'b1);
                add_request(VMIN, 1'b1);
                add_request(VMAX, 1'b1);
                // Two distinct values, each repeated.
                add_request(3, 1'b0);
                add_request(3, 1'b0);
                add_request(-3, 1'b0);
                add_request(-3, 1'b1);
                wait_requests_sent();

                // Phase 1: slow receiver. Start with a long hold-off while short
                // sets keep coming, so the block backs up and raises full.
                @(posedge clk);
                send_idle_pct = 6;
                recv_idle_pct = 65;
                hold_off_asks++;
                add_random_sets(80, 2);
                add_random_sets(300, 8);
                wait_requests_sent();

                // Stop sending until every answer is back.
                wait_answers_in();

                // Phase 2: slow sender, eager receiver.
                @(posedge clk);
                send_idle_pct = 65;
                recv_idle_pct = 6;
                add_random_sets(400, 8);
                wait_requests_sent();

                // Phase 3: full rate on both sides.
                @(posedge clk);
                send_idle_pct = 0;
                recv_idle_pct = 0;
                add_random_sets(400, 8);

                wait_answers_in();
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                while (quiet_cycles < QUIET_LIMIT)
                    @(posedge clk);
            end
        join_any

        if (quiet_cycles < QUIET_LIMIT && mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/smmd_pkg.sv
rtl/smmd_front.sv
rtl/smmd_queue.sv
rtl/smmd_back.sv
rtl/second_min_max_distinct.sv
test/tb_second_min_max_distinct.sv
